/* hw/rtl/fms_pkg.sv */
// Shared types, codes and helpers for the flight mode sequencer.
package fms_pkg;

  localparam int unsigned TDATA_IN_W  = 48;
  localparam int unsigned TDATA_OUT_W = 24;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 17;

  localparam logic [7:0] POWER_LOW_LIMIT = 8'd10;
  localparam logic [7:0] COUNT_MAX       = 8'd255;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_TAKEOFF_TICKS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAKEOFF_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_TOL      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LANDING_DIST    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_LIMIT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SPEED     = 3'd5;

  // Mode codes as reported on the output
  localparam logic [2:0] MODE_CODE_OFF      = 3'd0;
  localparam logic [2:0] MODE_CODE_INIT     = 3'd1;
  localparam logic [2:0] MODE_CODE_STARTING = 3'd2;
  localparam logic [2:0] MODE_CODE_TAKEOFF  = 3'd3;
  localparam logic [2:0] MODE_CODE_HOVERING = 3'd4;
  localparam logic [2:0] MODE_CODE_LANDING  = 3'd5;
  localparam logic [2:0] MODE_CODE_TESTING  = 3'd6;

  typedef enum logic [6:0] {
    ST_OFF      = 7'b0000001,
    ST_INIT     = 7'b0000010,
    ST_STARTING = 7'b0000100,
    ST_TAKEOFF  = 7'b0001000,
    ST_HOVERING = 7'b0010000,
    ST_LANDING  = 7'b0100000,
    ST_TESTING  = 7'b1000000
  } mode_t;

  typedef struct packed {
    logic [7:0]  takeoff_ticks;
    logic [15:0] target_height_mm;
    logic [15:0] height_tolerance_mm;
    logic [15:0] land_floor_mm;
    logic [16:0] height_limit_pa;
    logic [11:0] idle_speed;
  } cfg_t;

  typedef struct packed {
    logic        power_present;
    logic        sensors_stable;
    logic [15:0] lidar_mm;
    logic [16:0] pressure_pa;
    logic [11:0] motor_speed_avg;
  } item_t;

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  power_low_count;
    logic [7:0]  stable_count;
    logic [16:0] ground_pressure;
  } fms_state_t;

  function automatic logic [2:0] mode_code(input mode_t m);
    logic [2:0] code;
    case (m)
      ST_OFF:      code = MODE_CODE_OFF;
      ST_INIT:     code = MODE_CODE_INIT;
      ST_STARTING: code = MODE_CODE_STARTING;
      ST_TAKEOFF:  code = MODE_CODE_TAKEOFF;
      ST_HOVERING: code = MODE_CODE_HOVERING;
      ST_LANDING:  code = MODE_CODE_LANDING;
      ST_TESTING:  code = MODE_CODE_TESTING;
      default:     code = MODE_CODE_OFF;
    endcase
    return code;
  endfunction

endpackage

/* hw/rtl/fms_cfg.sv */
// Configuration register file of the flight mode sequencer.
module fms_cfg import fms_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.takeoff_ticks       <= 8'd30;
      cfg.target_height_mm    <= 16'd1000;
      cfg.height_tolerance_mm <= 16'd100;
      cfg.land_floor_mm       <= 16'd200;
      cfg.height_limit_pa     <= 17'd100;
      cfg.idle_speed          <= 12'd1100;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TAKEOFF_TICKS:  cfg.takeoff_ticks       <= cfg_data[7:0];
        CFG_TAKEOFF_HEIGHT: cfg.target_height_mm    <= cfg_data[15:0];
        CFG_HEIGHT_TOL:     cfg.height_tolerance_mm <= cfg_data[15:0];
        CFG_LANDING_DIST:   cfg.land_floor_mm       <= cfg_data[15:0];
        CFG_HEIGHT_LIMIT:   cfg.height_limit_pa     <= cfg_data;
        CFG_START_SPEED:    cfg.idle_speed          <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/fms_step.sv */
// Per-tick next-state logic: power failsafe, then one mode transition.
module fms_step import fms_pkg::*; (
  input  fms_state_t state,
  input  item_t      item,
  input  cfg_t       cfg,
  output fms_state_t state_next
);

  logic [7:0]  plc_next;
  logic        forced_off;
  mode_t       mode_fs;
  logic [15:0] diff;
  logic [17:0] press_limit;
  logic [7:0]  sc_inc;

  always_comb begin
    plc_next = 8'd0;
    if (!item.power_present) begin
      plc_next = (state.power_low_count == COUNT_MAX) ? COUNT_MAX
                                                       : state.power_low_count + 8'd1;
    end
    forced_off = !item.power_present && (plc_next > POWER_LOW_LIMIT) &&
                 (state.mode != ST_OFF) && (state.mode != ST_TESTING);
    mode_fs = forced_off ? ST_OFF : state.mode;

    diff = (item.lidar_mm >= cfg.target_height_mm) ?
           item.lidar_mm - cfg.target_height_mm :
           cfg.target_height_mm - item.lidar_mm;
    press_limit = {1'b0, state.ground_pressure} + {1'b0, cfg.height_limit_pa};
    sc_inc = (state.stable_count == COUNT_MAX) ? COUNT_MAX : state.stable_count + 8'd1;

    state_next                 = state;
    state_next.power_low_count = plc_next;
    state_next.mode            = mode_fs;

    case (mode_fs)
      ST_OFF: begin
        if (item.power_present) state_next.mode = ST_INIT;
      end
      ST_INIT: state_next.mode = ST_STARTING;
      ST_STARTING: begin
        if (item.sensors_stable) begin
          state_next.stable_count = sc_inc;
          if (sc_inc >= cfg.takeoff_ticks) state_next.mode = ST_TAKEOFF;
        end else begin
          state_next.stable_count = 8'd0;
        end
      end
      ST_TAKEOFF: begin
        if (diff <= cfg.height_tolerance_mm) state_next.mode = ST_HOVERING;
      end
      ST_HOVERING: begin
        if ((item.lidar_mm < cfg.land_floor_mm) ||
            ({1'b0, item.pressure_pa} > press_limit))
          state_next.mode = ST_LANDING;
      end
      ST_LANDING: begin
        if (item.motor_speed_avg <= cfg.idle_speed) state_next.mode = ST_TESTING;
      end
      default: ;
    endcase

    if (state_next.mode == ST_INIT) state_next.ground_pressure = item.pressure_pa;
  end

endmodule

/* hw/rtl/flight_mode_sequencer.sv */
// Flight mode sequencer: one control tick in, the resulting mode out.
//
// Each beat on s_axis is one control tick (power level, stable flag, lidar,
// pressure, motor speed). The block runs the power-off failsafe and at most
// one mode transition, and returns one beat on m_axis with the new mode and
// the captured base pressure.
// A beat accepted on s_axis goes through the input register, then the result
// register, before it is presented on m_axis. Throughput: one beat per cycle
// unless m_axis stalls; the mode update between them is a single compare pass.
// The user must write thresholds over the cfg channel (always ready) only while idle; not enforced.
// Reset (rst, synchronous) puts the mode at off, clears both counters and
// the base pressure, and loads the default thresholds.
// When m_axis stalls, the result register holds its beat and the input
// register may still take one more beat; s_axis_tready then drops until
// the result is taken.
module flight_mode_sequencer import fms_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [0] power_present, [1] sensors_stable, [17:2] lidar_mm,
  // [34:18] pressure_pa, [46:35] motor_speed_avg, [47] zero
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [2:0] mode, [19:3] base_pressure, [23:20] zero
  output logic [TDATA_OUT_W-1:0] m_axis_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t       cfg;
  fms_state_t state;
  fms_state_t state_next;
  item_t      in_item;
  logic       in_valid;
  logic       advance;
  logic       out_valid;
  logic [2:0] out_mode;
  logic [16:0] out_base;

  fms_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fms_step u_step (
    .state      (state),
    .item       (in_item),
    .cfg        (cfg),
    .state_next (state_next)
  );

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.power_present   <= s_axis_tdata[0];
      in_item.sensors_stable  <= s_axis_tdata[1];
      in_item.lidar_mm        <= s_axis_tdata[17:2];
      in_item.pressure_pa     <= s_axis_tdata[34:18];
      in_item.motor_speed_avg <= s_axis_tdata[46:35];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode            <= ST_OFF;
      state.power_low_count <= 8'd0;
      state.stable_count    <= 8'd0;
      state.ground_pressure <= 17'd0;
      out_valid             <= 1'b0;
    end else begin
      if (advance) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_mode <= mode_code(state_next.mode);
      out_base <= state_next.ground_pressure;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_base, out_mode};

  // Failsafe must have left the craft off (or done) once the low count is past the limit
  a_failsafe: assert property (@(posedge clk) disable iff (rst)
    (state.power_low_count > POWER_LOW_LIMIT) |->
      (state.mode == ST_OFF || state.mode == ST_TESTING))
    else $error("mode active with power low past limit");

  // Base pressure only changes on entry to init
  a_base_capture: assert property (@(posedge clk) disable iff (rst)
    (state.ground_pressure != $past(state.ground_pressure)) |-> (state.mode == ST_INIT))
    else $error("base pressure changed outside init");

  // An empty input stage always takes a beat
  a_in_ready: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_axis_tready)
    else $error("input stage empty but not ready");

endmodule
